// File: rtl/core/tnp_pkg.sv
// Package for the text number parser: value width and character codes.
// No dependencies; imported by text_number_parser_unit.
`timescale 1ns / 1ps

package tnp_pkg;

    // Accumulator width; the result port is always OUT_BITS wide.
    localparam int VALUE_BITS = 32;
    localparam int OUT_BITS   = 32;
    localparam int CHAR_BITS  = 8;
    localparam int DIGIT_BITS = 4;

    localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UP_B   = 8'h42;
    localparam logic [CHAR_BITS-1:0] CH_UP_F   = 8'h46;
    localparam logic [CHAR_BITS-1:0] CH_UP_X   = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LO_B   = 8'h62;
    localparam logic [CHAR_BITS-1:0] CH_LO_F   = 8'h66;
    localparam logic [CHAR_BITS-1:0] CH_LO_X   = 8'h78;

    localparam logic [DIGIT_BITS-1:0] DIGIT_TEN = 4'd10;

endpackage

// File: rtl/core/text_number_parser_unit.sv
// Streaming ASCII-to-integer parser with 0x / 0b base prefix; depends on tnp_pkg.
// A terminating byte's result is loaded into the output register.
// Throughput: one character per cycle; the only loop is the registered
// accumulator update (shift-add by the base). Input stalls only while a
// finished result is held stalled in the output register.
// Reset (rst_n, async low): expect a new string, decimal, accumulator zero.
`timescale 1ns / 1ps

module text_number_parser_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tnp_pkg::CHAR_BITS-1:0]   char_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tnp_pkg::OUT_BITS-1:0]    value,
    output logic                            bad_char
);
    import tnp_pkg::*;

    typedef enum logic [1:0] {
        PH_FIRST      = 2'd0,
        PH_AFTER_ZERO = 2'd1,
        PH_DIGITS     = 2'd2,
        PH_DROP       = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_HEX = 2'd1,
        RX_BIN = 2'd2
    } radix_t;

    phase_t                 phase_reg, phase_next;
    radix_t                 radix_reg, radix_next;
    logic [VALUE_BITS-1:0]  acc_reg, acc_next;
    logic                   out_valid_reg;
    logic [OUT_BITS-1:0]    value_reg;
    logic                   bad_reg;

    logic                   in_accept;
    logic                   is_digit;
    logic [DIGIT_BITS-1:0]  digit;
    logic                   is_prefix;
    radix_t                 prefix_radix;
    logic [VALUE_BITS-1:0]  scaled;
    logic                   emit;
    logic                   emit_bad;

    // Hold the input only while a result sits in the output register and
    // the far side is stalling it.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // Character classification.
    always_comb
    begin
        is_digit = 1'b1;
        digit    = '0;
        if (char_in inside {[CH_ZERO:CH_NINE]})
        begin
            digit = DIGIT_BITS'(char_in - CH_ZERO);
        end
        else if (char_in inside {[CH_UP_A:CH_UP_F]})
        begin
            digit = DIGIT_BITS'(char_in - CH_UP_A) + DIGIT_TEN;
        end
        else if (char_in inside {[CH_LO_A:CH_LO_F]})
        begin
            digit = DIGIT_BITS'(char_in - CH_LO_A) + DIGIT_TEN;
        end
        else
        begin
            is_digit = 1'b0;
        end
    end

    // Prefix letter after a leading zero; it wins over the hex digit 'b'.
    always_comb
    begin
        prefix_radix = RX_DEC;
        is_prefix    = 1'b0;
        if (phase_reg == PH_AFTER_ZERO)
        begin
            if (char_in inside {CH_LO_X, CH_UP_X})
            begin
                is_prefix    = 1'b1;
                prefix_radix = RX_HEX;
            end
            else if (char_in inside {CH_LO_B, CH_UP_B})
            begin
                is_prefix    = 1'b1;
                prefix_radix = RX_BIN;
            end
        end
    end

    // acc * base as shifts; unused radix code acts as decimal.
    always_comb
    begin
        case (radix_reg)
            RX_HEX:  scaled = {acc_reg[VALUE_BITS-5:0], 4'b0000};
            RX_BIN:  scaled = {acc_reg[VALUE_BITS-2:0], 1'b0};
            default: scaled = {acc_reg[VALUE_BITS-4:0], 3'b000}
                              + {acc_reg[VALUE_BITS-2:0], 1'b0};
        endcase
    end

    // Next state of the parser for the current character.
    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        emit       = 1'b0;
        emit_bad   = 1'b0;
        case (phase_reg)
            PH_DROP:
            begin
                // Drop everything up to the terminating zero byte.
                if (char_in == CH_NUL)
                begin
                    phase_next = PH_FIRST;
                    radix_next = RX_DEC;
                    acc_next   = '0;
                end
            end
            default:
            begin
                if (is_prefix)
                begin
                    radix_next = prefix_radix;
                    acc_next   = '0;
                    phase_next = PH_DIGITS;
                end
                else if (char_in == CH_NUL)
                begin
                    emit       = 1'b1;
                    phase_next = PH_FIRST;
                    radix_next = RX_DEC;
                    acc_next   = '0;
                end
                else if (!is_digit)
                begin
                    emit       = 1'b1;
                    emit_bad   = 1'b1;
                    phase_next = PH_DROP;
                    radix_next = RX_DEC;
                    acc_next   = '0;
                end
                else if (phase_reg == PH_FIRST)
                begin
                    radix_next = RX_DEC;
                    if (char_in == CH_ZERO)
                    begin
                        acc_next   = '0;
                        phase_next = PH_AFTER_ZERO;
                    end
                    else
                    begin
                        acc_next   = VALUE_BITS'(digit);
                        phase_next = PH_DIGITS;
                    end
                end
                else
                begin
                    acc_next   = scaled + VALUE_BITS'(digit);
                    phase_next = PH_DIGITS;
                end
            end
        endcase
    end

    // Parser state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            radix_reg     <= RX_DEC;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg <= phase_next;
                radix_reg <= radix_next;
                acc_reg   <= acc_next;
            end
            // Load a new result, otherwise drop a result that was taken.
            if (in_accept && emit)
            begin
                out_valid_reg <= 1'b1;
                value_reg     <= OUT_BITS'(acc_reg);
                bad_reg       <= emit_bad;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign bad_char  = bad_reg;

    // A zero byte outside the dropping phase produces a clean result.
    a_nul_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (phase_reg != PH_DROP) && (char_in == CH_NUL)
        |=> out_valid && !bad_char)
        else $error("zero byte did not produce a clean result");

    // Bytes in the dropping phase never produce a result.
    a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (phase_reg == PH_DROP) |=> !out_valid)
        else $error("dropped byte produced a result");

    // A pending error result implies the parser is dropping the rest.
    a_bad_drops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_char |-> phase_reg == PH_DROP)
        else $error("error result without dropping phase");

endmodule

// File: tb/tb_text_number_parser_unit.sv
// Self-checking testbench for text_number_parser_unit: directed and random number strings.
// Depends on tnp_pkg and text_number_parser_unit; needs no files or arguments.
`timescale 1ns / 1ps

module tb_text_number_parser_unit;

    import tnp_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 3;
    localparam int CYCLE_LIMIT = 200_000;  // watchdog limit; a clean run stays well below it
    localparam int HOLD_CYCLES = 60;       // long receiver hold-off, enough to back up the input
    localparam int MODE_ITEMS  = 300;      // random characters per idling mode
    localparam int DRAIN_WAIT  = 4;        // final wait before the last check

    typedef enum logic [1:0] {PH_FIRST, PH_AFTER_ZERO, PH_DIGITS, PH_DROP} parse_phase_t;
    typedef enum logic [1:0] {RX_DEC, RX_HEX, RX_BIN} radix_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] value;
        logic                bad;
    } parsed_number_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [CHAR_BITS-1:0] char_in;
    logic                 out_valid;
    logic                 out_stall;
    logic [OUT_BITS-1:0]  value;
    logic                 bad_char;

    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;
    bit          hold_request;
    int          chars_sent;
    int          cycle_count;

    // Return 1 and the digit if c is one of 0-9, A-F, a-f.
    function automatic bit digit_value(input logic [CHAR_BITS-1:0] c,
                                       output logic [DIGIT_BITS-1:0] d);
        d = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = DIGIT_BITS'(c - CH_ZERO);
            return 1'b1;
        end
        if (c >= CH_UP_A && c <= CH_UP_F)
        begin
            d = DIGIT_BITS'(c - CH_UP_A) + DIGIT_TEN;
            return 1'b1;
        end
        if (c >= CH_LO_A && c <= CH_LO_F)
        begin
            d = DIGIT_BITS'(c - CH_LO_A) + DIGIT_TEN;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Tracks the parse of the accepted character stream and checks every number that comes out.
    class number_checker;
        parse_phase_t           phase;
        radix_t                 radix;
        logic [VALUE_BITS-1:0]  accum;
        bit                     lead_zero;
        parsed_number_t         pending_numbers[$];
        int                     mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            phase     = PH_FIRST;
            radix     = RX_DEC;
            accum     = '0;
            lead_zero = 1'b0;
        endfunction

        function logic [VALUE_BITS-1:0] radix_base();
            case (radix)
                RX_HEX:  return VALUE_BITS'(16);
                RX_BIN:  return VALUE_BITS'(2);
                default: return VALUE_BITS'(10);
            endcase
        endfunction

        function void queue_number(input logic bad);
            parsed_number_t num;
            num.value = accum[OUT_BITS-1:0];
            num.bad   = bad;
            pending_numbers.push_back(num);
        endfunction

        // Advance the parse by one accepted request.
        function void take_char(input logic [CHAR_BITS-1:0] c);
            logic [DIGIT_BITS-1:0] d;
            bit                    is_digit;
            is_digit = digit_value(c, d);
            if (phase == PH_DROP)
            begin
                if (c == CH_NUL)
                    restart();
                return;
            end
            if (phase == PH_AFTER_ZERO)
            begin
                if (c == CH_LO_X || c == CH_UP_X || c == CH_LO_B || c == CH_UP_B)
                begin
                    radix = (c == CH_LO_X || c == CH_UP_X) ? RX_HEX : RX_BIN;
                    accum = '0;
                    phase = PH_DIGITS;
                    return;
                end
                phase = PH_DIGITS;
            end
            if (c == CH_NUL)
            begin
                queue_number(1'b0);
                restart();
                return;
            end
            if (!is_digit)
            begin
                queue_number(1'b1);
                restart();
                phase = PH_DROP;
                return;
            end
            if (phase == PH_FIRST)
            begin
                accum = '0;
                radix = RX_DEC;
                if (c == CH_ZERO)
                begin
                    lead_zero = 1'b1;
                    phase     = PH_AFTER_ZERO;
                    return;
                end
                phase = PH_DIGITS;
            end
            accum = accum * radix_base() + VALUE_BITS'(d);
        endfunction

        task flag_mismatch(input string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task compare_number(input logic [OUT_BITS-1:0] got_value, input logic got_bad);
            parsed_number_t want;
            if (pending_numbers.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result value=%h bad_char=%b",
                                        got_value, got_bad));
                return;
            end
            want = pending_numbers.pop_front();
            if (got_value !== want.value)
                flag_mismatch($sformatf("value %h, expected %h", got_value, want.value));
            if (got_bad !== want.bad)
                flag_mismatch($sformatf("bad_char %b, expected %b", got_bad, want.bad));
        endtask

        function int outstanding();
            return pending_numbers.size();
        endfunction
    endclass

    number_checker checker_h = new();

    text_number_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_in   (char_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .bad_char  (bad_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog: give up if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Sample both handshakes at the edge; every signal seen here still holds its pre-edge value.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                checker_h.take_char(char_in);
            if (out_valid && !out_stall)
                checker_h.compare_number(value, bad_char);
        end
    end

    // Receiver: stall at random, or hold off for a long counted stretch when asked.
    initial
    begin
        int hold_count;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall  <= 1'b1;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    hold_count++;
                end
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= (receiver_idle_pct != 0) &&
                             ($urandom_range(99) < receiver_idle_pct);
            end
        end
    end

    // Offer one character and hold it until the request is taken.
    task automatic send_char(input logic [CHAR_BITS-1:0] c);
        // Idle at random before offering, at the sender's idling rate.
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        do @(posedge clk); while (in_stall);
        chars_sent++;
    endtask

    // Send the text and close it with a zero byte.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        send_char(CH_NUL);
    endtask

    function automatic logic [CHAR_BITS-1:0] digit_char(input int unsigned d);
        if (d < 10)
            return CH_ZERO + CHAR_BITS'(d);
        return ($urandom_range(1) ? CH_UP_A : CH_LO_A) + CHAR_BITS'(d - 10);
    endfunction

    // Pick a nonzero byte that is not a digit character.
    function automatic logic [CHAR_BITS-1:0] invalid_char();
        logic [CHAR_BITS-1:0]  c;
        logic [DIGIT_BITS-1:0] d;
        do c = CHAR_BITS'($urandom_range(1, 255)); while (digit_value(c, d));
        return c;
    endfunction

    // Mostly well-formed strings with an optional prefix; some break on a bad character,
    // a few are plain byte noise.
    task automatic send_random_string();
        int unsigned kind;
        int unsigned ndig;
        int unsigned dmax;
        int          bad_at;
        if ($urandom_range(99) < 8)
        begin
            repeat ($urandom_range(1, 6)) send_char(CHAR_BITS'($urandom_range(0, 255)));
            return;
        end
        kind   = $urandom_range(2);  // 0: decimal, 1: hex prefix, 2: binary prefix
        ndig   = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6);
        bad_at = ($urandom_range(99) < 15) ? int'($urandom_range(0, ndig)) : -1;
        if (kind == 1)
        begin
            send_char(CH_ZERO);
            send_char($urandom_range(1) ? CH_LO_X : CH_UP_X);
        end
        else if (kind == 2)
        begin
            send_char(CH_ZERO);
            send_char($urandom_range(1) ? CH_LO_B : CH_UP_B);
        end
        for (int i = 0; i <= ndig; i++)
        begin
            if (i == bad_at)
            begin
                // bad character, then junk that the block drops up to the zero byte
                send_char(invalid_char());
                repeat ($urandom_range(0, 3)) send_char(CHAR_BITS'($urandom_range(1, 255)));
                break;
            end
            if (i < ndig)
            begin
                dmax = (kind == 1) ? 15 : (kind == 2) ? 1 : 9;
                if ($urandom_range(9) == 0)
                    dmax = 15;  // digits beyond the base are still accumulated
                send_char(digit_char($urandom_range(dmax)));
            end
        end
        send_char(CH_NUL);
    endtask

    // Drop valid and wait until every expected number has come out; the extra edge
    // lets the sampler note the last request first.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (checker_h.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int mode_end;
        rst_n             <= 1'b0;
        in_valid          <= 1'b0;
        char_in           <= CH_NUL;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_request      = 1'b0;
        chars_sent        = 0;
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings
        send_char(CH_NUL);          // empty string
        send_text("0x");            // bare hex prefix
        send_text("0Bb");           // binary prefix, digit beyond base
        send_text("07");            // leading zero stays a decimal digit
        send_text("9aA");           // letters in decimal
        send_char("1");             // top byte is invalid, then drop up to the zero byte
        send_char(8'hFF);
        send_char(8'h7F);
        send_char(CH_NUL);
        send_text("0g");            // invalid right after the leading zero
        send_text("0XfF");
        drain();

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    sender_idle_pct   = 31;
                    receiver_idle_pct = 85;
                end
                1:
                begin
                    sender_idle_pct   = 85;
                    receiver_idle_pct = 31;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            if (mode == 2)
            begin
                // Hold the output off while short strings keep coming, so the input backs up.
                hold_request = 1'b1;
                repeat (10) send_text(string'(digit_char($urandom_range(9))));
            end
            mode_end = chars_sent + MODE_ITEMS;
            while (chars_sent < mode_end)
                send_random_string();
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (checker_h.mismatches == 0 && checker_h.outstanding() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: text_number_parser_unit.f
rtl/core/tnp_pkg.sv
rtl/core/text_number_parser_unit.sv
tb/tb_text_number_parser_unit.sv
